FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the residency manager RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising edge outside reset.
`define BRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define BRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/brm_pkg.sv
// ---------------------------------------------------------------------------
// brm_pkg
// Types, codes and widths shared by the residency manager modules.
// ---------------------------------------------------------------------------
package brm_pkg;

  localparam int unsigned MAX_ASSETS_DEF = 32;
  localparam int unsigned BUDGET_W       = 48;
  localparam int unsigned COST_W         = 40;
  localparam int unsigned STAMP_W        = 32;
  localparam int unsigned PRIO_W         = 8;
  localparam int unsigned PLEVEL_W       = 7;
  localparam int unsigned ID_W           = 5;
  localparam int unsigned KEY_ID_W       = 6;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam logic [PLEVEL_W-1:0] PLEVEL_RESET = 7'd127;
  // Pending work above this margin (and not negative) skips an iteration.
  localparam logic [STAMP_W-1:0] SKIP_MARGIN = 32'd3;

  typedef enum logic [2:0] {
    MODE_REGISTER  = 3'd0,
    MODE_UPDATE    = 3'd1,
    MODE_MARK_USED = 3'd2,
    MODE_SET_PRIO  = 3'd3,
    MODE_ITERATE   = 3'd4,
    MODE_SINGLE    = 3'd5
  } brm_mode_e;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_ACTIVATE   = 3'd1,
    KIND_RELEASE    = 3'd2,
    KIND_STATUS     = 3'd3,
    KIND_SKIPPED    = 3'd4,
    KIND_DONE       = 3'd5
  } brm_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_BUDGET  = 2'd0,
    CFG_ITER_BUDGET   = 2'd1,
    CFG_PERSIST_LEVEL = 2'd2
  } brm_cfg_e;

  // One asset record as held in the record memory.
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [STAMP_W-1:0] last_use;
    logic [COST_W-1:0]  res;
    logic [COST_W-1:0]  pend;
    logic [COST_W-1:0]  est;
  } brm_rec_t;

  // Ordering key of one asset.
  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [STAMP_W-1:0]  last_use;
    logic [COST_W-1:0]   res;
    logic [COST_W-1:0]   pend;
    logic [KEY_ID_W-1:0] id;
  } brm_key_t;

endpackage

FILE: sv/brm_ram.sv
// ---------------------------------------------------------------------------
// brm_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
module brm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/brm_cmp.sv
// ---------------------------------------------------------------------------
// brm_cmp
// Ordering comparator: tells whether asset a goes before asset b.
// ---------------------------------------------------------------------------
module brm_cmp (
  input  brm_pkg::brm_key_t a_i,
  input  brm_pkg::brm_key_t b_i,
  output logic              before_o
);

  // Priority descending, last use descending, resident cost ascending,
  // pending cost descending, id ascending.
  always_comb begin
    if (a_i.prio != b_i.prio) begin
      before_o = $signed(a_i.prio) > $signed(b_i.prio);
    end else if (a_i.last_use != b_i.last_use) begin
      before_o = a_i.last_use > b_i.last_use;
    end else if (a_i.res != b_i.res) begin
      before_o = a_i.res < b_i.res;
    end else if (a_i.pend != b_i.pend) begin
      before_o = a_i.pend > b_i.pend;
    end else begin
      before_o = a_i.id < b_i.id;
    end
  end

endmodule

FILE: sv/budgeted_residency_manager.sv
// ---------------------------------------------------------------------------
// budgeted_residency_manager
// Asset table with deferred updates and budgeted activate/release iterations.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                     Payload
//  -------   ---------------------------   -----------------------------------
//  command   start_i, busy_o               mode_i, asset_id_i, priority_req_i,
//                                          cost_i, completed_count_i
//  result    result_valid_o (strobe)       kind_o, result_id_o, ok_o,
//                                          result_cost_o, total_used_o, last_o
//  config    cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// Register, cost update, mark used and unknown commands finish in the cycle
// they are accepted; set priority goes on to a write state, S_PRIO_WR. The
// length of an iteration is set by the rank pass, which reads every record
// once for every asset over the single read port of the record memory. A
// single activation first runs the deferred-update sweep, then its own read
// and check states.
// Reset clears all control state and the valid and used flags; the memories
// are not cleared. The receiver cannot stall: each result is shown for one
// cycle, and busy_o is already low when the last result of a command is shown.
//
// The record memory holds priority, last-use stamp, resident, pending and
// estimated cost of each asset. Each access is a read followed by a write in
// a later state, so a write never changes an entry before its read data has
// been taken; the state sequence is the interlock.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module budgeted_residency_manager #(
  parameter int unsigned MAX_ASSETS = brm_pkg::MAX_ASSETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command transaction.
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [2:0]                     mode_i,
  input  logic [brm_pkg::ID_W-1:0]       asset_id_i,
  input  logic signed [brm_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [brm_pkg::COST_W-1:0]     cost_i,
  input  logic [brm_pkg::STAMP_W-1:0]    completed_count_i,
  // Result transaction.
  output logic                           result_valid_o,
  output logic [2:0]                     kind_o,
  output logic [brm_pkg::ID_W-1:0]       result_id_o,
  output logic                           ok_o,
  output logic [brm_pkg::COST_W-1:0]     result_cost_o,
  output logic [brm_pkg::BUDGET_W-1:0]   total_used_o,
  output logic                           last_o,
  // Configuration transaction.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [brm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [brm_pkg::BUDGET_W-1:0]   cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_ASSETS);
  localparam int unsigned CW    = $clog2(MAX_ASSETS + 1);
  localparam int unsigned ACT_W = brm_pkg::COST_W + CW;
  localparam int unsigned BW    = brm_pkg::BUDGET_W;
  localparam int unsigned KW    = brm_pkg::COST_W;
  localparam int unsigned SW    = brm_pkg::STAMP_W;
  localparam int unsigned RW    = $bits(brm_pkg::brm_rec_t);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_PRIO_WR = 20'h00002,
    S_AP_RD   = 20'h00004,
    S_AP_EX   = 20'h00008,
    S_SA_RD   = 20'h00010,
    S_SA_EX   = 20'h00020,
    S_RK_RDA  = 20'h00040,
    S_RK_LDA  = 20'h00080,
    S_RK_CMP  = 20'h00100,
    S_W_CHK   = 20'h00200,
    S_W_ORD   = 20'h00400,
    S_W_REC   = 20'h00800,
    S_W_RCHK  = 20'h01000,
    S_W_RORD  = 20'h02000,
    S_W_RREC  = 20'h04000,
    S_W_ACT   = 20'h08000,
    S_L2_CHK  = 20'h10000,
    S_L2_ORD  = 20'h20000,
    S_L2_REC  = 20'h40000,
    S_DONE    = 20'h80000
  } state_e;

  typedef struct packed {
    logic                     valid;
    logic [2:0]               kind;
    logic [brm_pkg::ID_W-1:0] id;
    logic                     ok;
    logic [KW-1:0]            cost;
    logic                     last;
  } emit_t;

  function automatic emit_t mk_em(input logic [2:0] kind, input logic [brm_pkg::ID_W-1:0] id,
                                  input logic ok, input logic [KW-1:0] cost,
                                  input logic last);
    emit_t e;
    e.valid = 1'b1;
    e.kind  = kind;
    e.id    = id;
    e.ok    = ok;
    e.cost  = cost;
    e.last  = last;
    return e;
  endfunction

  // Control state.
  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [SW-1:0]           stamp_q, stamp_d;
  logic [SW-1:0]           single_q, single_d;
  logic [BW-1:0]           used_q, used_d;
  logic [BW-1:0]           tb_q, tb_d;
  logic [BW-1:0]           ib_q, ib_d;
  logic [brm_pkg::PLEVEL_W-1:0] pl_q, pl_d;
  logic [MAX_ASSETS-1:0]   def_vld_q, def_vld_d;
  logic [MAX_ASSETS-1:0]   used_flg_q, used_flg_d;
  logic [CW-1:0]           i_q, i_d;
  logic [CW-1:0]           jc_q, jc_d;
  logic [CW-1:0]           rank_q, rank_d;
  logic [CW-1:0]           ai_q, ai_d;
  logic [CW-1:0]           ri_q, ri_d;
  logic                    can_q, can_d;
  logic [ACT_W-1:0]        act_q, act_d;
  logic                    is_single_q, is_single_d;
  logic                    res_valid_q;

  // Payload state.
  brm_pkg::brm_key_t       key_a_q, key_a_d;
  brm_pkg::brm_rec_t       crec_q, crec_d;
  logic [AW-1:0]           c_q, c_d;
  logic [AW-1:0]           r_q, r_d;
  logic [6:0]              id_q, id_d;
  logic [6:0]              id_w;
  logic [brm_pkg::PRIO_W-1:0] prio_q, prio_d;
  emit_t                   em, em_q;
  logic [BW-1:0]           total_q;

  // Memory ports.
  logic                    rec_we;
  logic [AW-1:0]           rec_waddr, rec_raddr;
  brm_pkg::brm_rec_t       rec_wdata, rec_rd;
  logic [RW-1:0]           rec_rdata;
  logic                    ord_we;
  logic [AW-1:0]           ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic                    def_we;
  logic [AW-1:0]           def_raddr;
  logic [KW-1:0]           def_rdata;

  brm_ram #(.WIDTH(RW), .DEPTH(MAX_ASSETS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  // Rank-to-asset map built by the rank pass.
  brm_ram #(.WIDTH(AW), .DEPTH(MAX_ASSETS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // Deferred measured costs; their valid bits live in flip-flops.
  brm_ram #(.WIDTH(KW), .DEPTH(MAX_ASSETS)) u_def_ram (
    .clk_i   (clk_i),
    .we_i    (def_we),
    .waddr_i (id_w[AW-1:0]),
    .wdata_i (cost_i),
    .raddr_i (def_raddr),
    .rdata_o (def_rdata)
  );

  assign rec_rd = brm_pkg::brm_rec_t'(rec_rdata);

  // The record being read is compared against the latched key of asset i.
  brm_pkg::brm_key_t key_b;
  logic              j_before;

  assign key_b = '{prio: rec_rd.prio, last_use: rec_rd.last_use, res: rec_rd.res,
                   pend: rec_rd.pend, id: brm_pkg::KEY_ID_W'(jc_q)};

  brm_cmp u_cmp (
    .a_i      (key_b),
    .b_i      (key_a_q),
    .before_o (j_before)
  );

  // Decoded command and helper arithmetic.
  logic                    accept;
  brm_pkg::brm_mode_e      mode_e;
  logic                    id_ok_max, id_in_tab, id_q_in_tab;
  logic [SW-1:0]           stamp_sum, pend_work;
  logic                    skip;
  logic [BW-1:0]           used_rel;
  logic                    fit_rec, fit_rel, persist_rd, prio_pos;
  logic [BW+1:0]           tb_x3;
  logic [BW-1:0]           low_mark;
  logic [CW-1:0]           rank_nx, jc_nx, ri_dec;

  assign accept      = start_i && (state_q == S_IDLE);
  assign mode_e      = brm_pkg::brm_mode_e'(mode_i);
  assign id_w        = 7'(asset_id_i);
  assign id_ok_max   = id_w < 7'(MAX_ASSETS);
  assign id_in_tab   = id_w < 7'(cnt_q);
  assign id_q_in_tab = id_q < 7'(cnt_q);
  assign stamp_sum   = stamp_q + single_q;
  assign pend_work   = stamp_sum - completed_count_i;
  assign skip        = !pend_work[SW-1] && (pend_work > brm_pkg::SKIP_MARGIN);
  assign used_rel    = used_q - BW'(rec_rd.res);
  assign fit_rec     = ({1'b0, used_q} + (BW+1)'(rec_rd.est)) <= {1'b0, tb_q};
  assign fit_rel     = ({1'b0, used_rel} + (BW+1)'(crec_q.est)) <= {1'b0, tb_q};
  assign persist_rd  = $signed(rec_rd.prio) >= $signed({1'b0, pl_q});
  assign prio_pos    = $signed(rec_rd.prio) > $signed(8'sd0);
  // Three quarters of the total budget, for the early-release rule.
  assign tb_x3       = {2'b00, tb_q} + {1'b0, tb_q, 1'b0};
  assign low_mark    = tb_x3[BW+1:2];
  assign rank_nx     = rank_q + CW'(j_before);
  assign jc_nx       = jc_q + 1'b1;
  assign ri_dec      = ri_q - 1'b1;

  // Registers are only taken while no command is in flight.
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    brm_pkg::brm_rec_t wrec;
    wrec        = rec_rd;
    state_d     = state_q;
    cnt_d       = cnt_q;
    stamp_d     = stamp_q;
    single_d    = single_q;
    used_d      = used_q;
    tb_d        = tb_q;
    ib_d        = ib_q;
    pl_d        = pl_q;
    def_vld_d   = def_vld_q;
    used_flg_d  = used_flg_q;
    i_d         = i_q;
    jc_d        = jc_q;
    rank_d      = rank_q;
    ai_d        = ai_q;
    ri_d        = ri_q;
    can_d       = can_q;
    act_d       = act_q;
    is_single_d = is_single_q;
    key_a_d     = key_a_q;
    crec_d      = crec_q;
    c_d         = c_q;
    r_d         = r_q;
    id_d        = id_q;
    prio_d      = prio_q;
    em          = '0;
    rec_we      = 1'b0;
    rec_waddr   = i_q[AW-1:0];
    rec_wdata   = rec_rd;
    rec_raddr   = i_q[AW-1:0];
    ord_we      = 1'b0;
    ord_waddr   = rank_nx[AW-1:0];
    ord_wdata   = i_q[AW-1:0];
    ord_raddr   = ai_q[AW-1:0];
    def_we      = 1'b0;
    def_raddr   = i_q[AW-1:0];

    // Configuration is only written while the block is idle.
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (brm_pkg::brm_cfg_e'(cfg_index_i))
        brm_pkg::CFG_TOTAL_BUDGET:  tb_d = cfg_data_i;
        brm_pkg::CFG_ITER_BUDGET:   ib_d = cfg_data_i;
        brm_pkg::CFG_PERSIST_LEVEL: pl_d = cfg_data_i[brm_pkg::PLEVEL_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d = id_w;
          unique case (mode_e)
            brm_pkg::MODE_REGISTER: begin
              if (cnt_q >= CW'(MAX_ASSETS)) begin
                em = mk_em(brm_pkg::KIND_REGISTERED, '0, 1'b0, '0, 1'b1);
              end else begin
                rec_we    = 1'b1;
                rec_waddr = cnt_q[AW-1:0];
                rec_wdata = '{prio: priority_req_i, last_use: '0, res: '0, pend: '0,
                              est: cost_i};
                cnt_d     = cnt_q + 1'b1;
                em = mk_em(brm_pkg::KIND_REGISTERED, brm_pkg::ID_W'(cnt_q), 1'b1, '0, 1'b1);
              end
            end
            brm_pkg::MODE_UPDATE: begin
              if (id_ok_max) begin
                def_we                   = 1'b1;
                def_vld_d[id_w[AW-1:0]]  = 1'b1;
              end
              em = mk_em(brm_pkg::KIND_STATUS, asset_id_i, id_ok_max, '0, 1'b1);
            end
            brm_pkg::MODE_MARK_USED: begin
              if (id_ok_max) begin
                used_flg_d[id_w[AW-1:0]] = 1'b1;
              end
              em = mk_em(brm_pkg::KIND_STATUS, asset_id_i, id_ok_max, '0, 1'b1);
            end
            brm_pkg::MODE_SET_PRIO: begin
              if (id_in_tab) begin
                rec_raddr = id_w[AW-1:0];
                prio_d    = priority_req_i;
                state_d   = S_PRIO_WR;
              end else begin
                em = mk_em(brm_pkg::KIND_STATUS, asset_id_i, 1'b0, '0, 1'b1);
              end
            end
            brm_pkg::MODE_ITERATE: begin
              stamp_d  = stamp_sum;
              single_d = '0;
              if (skip) begin
                em = mk_em(brm_pkg::KIND_SKIPPED, '0, 1'b1, '0, 1'b1);
              end else begin
                i_d         = '0;
                is_single_d = 1'b0;
                state_d     = S_AP_RD;
              end
            end
            brm_pkg::MODE_SINGLE: begin
              i_d         = '0;
              is_single_d = 1'b1;
              state_d     = S_AP_RD;
            end
            default: begin
              em = mk_em(brm_pkg::KIND_STATUS, asset_id_i, 1'b0, '0, 1'b1);
            end
          endcase
        end
      end

      S_PRIO_WR: begin
        wrec.prio = prio_q;
        rec_we    = 1'b1;
        rec_waddr = id_q[AW-1:0];
        rec_wdata = wrec;
        em        = mk_em(brm_pkg::KIND_STATUS, id_q[brm_pkg::ID_W-1:0], 1'b1, '0, 1'b1);
        state_d   = S_IDLE;
      end

      // Deferred-update sweep over the registered entries.
      S_AP_RD: begin
        if (i_q == cnt_q) begin
          def_vld_d  = '0;
          used_flg_d = '0;
          i_d        = '0;
          state_d    = is_single_q ? S_SA_RD : S_RK_RDA;
        end else begin
          state_d = S_AP_EX;
        end
      end

      S_AP_EX: begin
        if (def_vld_q[i_q[AW-1:0]]) begin
          used_d        = used_q + BW'(def_rdata) - BW'(rec_rd.res) - BW'(rec_rd.pend);
          wrec.res      = def_rdata;
          wrec.pend     = '0;
          wrec.last_use = stamp_q;
        end
        if (used_flg_q[i_q[AW-1:0]]) begin
          wrec.last_use = stamp_q;
        end
        rec_we    = def_vld_q[i_q[AW-1:0]] || used_flg_q[i_q[AW-1:0]];
        rec_wdata = wrec;
        i_d       = i_q + 1'b1;
        state_d   = S_AP_RD;
      end

      S_SA_RD: begin
        rec_raddr = id_q[AW-1:0];
        state_d   = S_SA_EX;
      end

      S_SA_EX: begin
        state_d = S_IDLE;
        if (!id_q_in_tab) begin
          em = mk_em(brm_pkg::KIND_STATUS, id_q[brm_pkg::ID_W-1:0], 1'b0, '0, 1'b1);
        end else if (rec_rd.res != '0 || rec_rd.pend != '0) begin
          em = mk_em(brm_pkg::KIND_STATUS, id_q[brm_pkg::ID_W-1:0], 1'b1, '0, 1'b1);
        end else begin
          wrec.pend     = rec_rd.est;
          wrec.last_use = stamp_q;
          rec_we        = 1'b1;
          rec_waddr     = id_q[AW-1:0];
          rec_wdata     = wrec;
          used_d        = used_q + BW'(rec_rd.est);
          single_d      = single_q + 1'b1;
          em = mk_em(brm_pkg::KIND_ACTIVATE, id_q[brm_pkg::ID_W-1:0], 1'b1, rec_rd.est, 1'b1);
        end
      end

      // Rank pass: each asset's rank is the number of assets going before it.
      S_RK_RDA: begin
        if (i_q == cnt_q) begin
          ai_d    = '0;
          ri_d    = cnt_q;
          can_d   = 1'b1;
          act_d   = '0;
          state_d = S_W_CHK;
        end else begin
          state_d = S_RK_LDA;
        end
      end

      S_RK_LDA: begin
        key_a_d = '{prio: rec_rd.prio, last_use: rec_rd.last_use, res: rec_rd.res,
                    pend: rec_rd.pend, id: brm_pkg::KEY_ID_W'(i_q)};
        rec_raddr = '0;
        jc_d      = '0;
        rank_d    = '0;
        state_d   = S_RK_CMP;
      end

      S_RK_CMP: begin
        rec_raddr = jc_nx[AW-1:0];
        if (jc_nx == cnt_q) begin
          ord_we  = 1'b1;
          i_d     = i_q + 1'b1;
          state_d = S_RK_RDA;
        end else begin
          jc_d   = jc_nx;
          rank_d = rank_nx;
        end
      end

      // Activation walk from the front of the order.
      S_W_CHK: begin
        if (can_q && (used_q < tb_q) && (BW'(act_q) < ib_q) && (ai_q != ri_q)) begin
          state_d = S_W_ORD;
        end else begin
          state_d = S_L2_CHK;
        end
      end

      S_W_ORD: begin
        c_d       = ord_rdata;
        rec_raddr = ord_rdata;
        state_d   = S_W_REC;
      end

      S_W_REC: begin
        crec_d = rec_rd;
        if (!prio_pos) begin
          state_d = S_L2_CHK;
        end else if (rec_rd.res != '0 || rec_rd.pend != '0) begin
          ai_d    = ai_q + 1'b1;
          state_d = S_W_CHK;
        end else if (fit_rec || persist_rd) begin
          wrec.pend = rec_rd.est;
          rec_we    = 1'b1;
          rec_waddr = c_q;
          rec_wdata = wrec;
          used_d    = used_q + BW'(rec_rd.est);
          act_d     = act_q + ACT_W'(rec_rd.est);
          ai_d      = ai_q + 1'b1;
          em = mk_em(brm_pkg::KIND_ACTIVATE, brm_pkg::ID_W'(c_q), 1'b1, rec_rd.est, 1'b0);
          state_d   = S_W_CHK;
        end else begin
          can_d   = 1'b0;
          state_d = S_W_RCHK;
        end
      end

      // Make room by releasing from the back of the order.
      S_W_RCHK: begin
        if ((ai_q + 1'b1) == ri_q) begin
          state_d = S_W_CHK;
        end else begin
          ri_d      = ri_dec;
          ord_raddr = ri_dec[AW-1:0];
          state_d   = S_W_RORD;
        end
      end

      S_W_RORD: begin
        r_d       = ord_rdata;
        rec_raddr = ord_rdata;
        state_d   = S_W_RREC;
      end

      S_W_RREC: begin
        if (rec_rd.res != '0) begin
          wrec.res  = '0;
          rec_we    = 1'b1;
          rec_waddr = r_q;
          rec_wdata = wrec;
          used_d    = used_rel;
          em = mk_em(brm_pkg::KIND_RELEASE, brm_pkg::ID_W'(r_q), 1'b1, rec_rd.res, 1'b0);
        end
        if (fit_rel) begin
          can_d   = 1'b1;
          state_d = S_W_ACT;
        end else begin
          state_d = S_W_RCHK;
        end
      end

      S_W_ACT: begin
        wrec      = crec_q;
        wrec.pend = crec_q.est;
        rec_we    = 1'b1;
        rec_waddr = c_q;
        rec_wdata = wrec;
        used_d    = used_q + BW'(crec_q.est);
        act_d     = act_q + ACT_W'(crec_q.est);
        ai_d      = ai_q + 1'b1;
        em = mk_em(brm_pkg::KIND_ACTIVATE, brm_pkg::ID_W'(c_q), 1'b1, crec_q.est, 1'b0);
        state_d   = S_W_CHK;
      end

      // Release pass: over budget, or above three quarters at priority zero.
      S_L2_CHK: begin
        if (ri_q == ai_q) begin
          state_d = S_DONE;
        end else begin
          ord_raddr = ri_dec[AW-1:0];
          state_d   = S_L2_ORD;
        end
      end

      S_L2_ORD: begin
        r_d       = ord_rdata;
        rec_raddr = ord_rdata;
        state_d   = S_L2_REC;
      end

      S_L2_REC: begin
        if (persist_rd ||
            !((used_q > tb_q) || ((used_q > low_mark) && (rec_rd.prio == '0)))) begin
          state_d = S_DONE;
        end else begin
          ri_d = ri_dec;
          if (rec_rd.res != '0) begin
            wrec.res      = '0;
            wrec.last_use = '0;
            rec_we        = 1'b1;
            rec_waddr     = r_q;
            rec_wdata     = wrec;
            used_d        = used_rel;
            em = mk_em(brm_pkg::KIND_RELEASE, brm_pkg::ID_W'(r_q), 1'b1, rec_rd.res, 1'b0);
          end
          state_d = S_L2_CHK;
        end
      end

      S_DONE: begin
        stamp_d = stamp_q + 1'b1;
        em = mk_em(brm_pkg::KIND_DONE, '0, 1'b1,
                   (act_q[ACT_W-1:KW] != '0) ? {KW{1'b1}} : act_q[KW-1:0], 1'b1);
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      stamp_q     <= '0;
      single_q    <= '0;
      used_q      <= '0;
      tb_q        <= '0;
      ib_q        <= '0;
      pl_q        <= brm_pkg::PLEVEL_RESET;
      def_vld_q   <= '0;
      used_flg_q  <= '0;
      i_q         <= '0;
      jc_q        <= '0;
      rank_q      <= '0;
      ai_q        <= '0;
      ri_q        <= '0;
      can_q       <= 1'b0;
      act_q       <= '0;
      is_single_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stamp_q     <= stamp_d;
      single_q    <= single_d;
      used_q      <= used_d;
      tb_q        <= tb_d;
      ib_q        <= ib_d;
      pl_q        <= pl_d;
      def_vld_q   <= def_vld_d;
      used_flg_q  <= used_flg_d;
      i_q         <= i_d;
      jc_q        <= jc_d;
      rank_q      <= rank_d;
      ai_q        <= ai_d;
      ri_q        <= ri_d;
      can_q       <= can_d;
      act_q       <= act_d;
      is_single_q <= is_single_d;
      res_valid_q <= em.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    key_a_q <= key_a_d;
    crec_q  <= crec_d;
    c_q     <= c_d;
    r_q     <= r_d;
    id_q    <= id_d;
    prio_q  <= prio_d;
    em_q    <= em;
    total_q <= used_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign kind_o         = em_q.kind;
  assign result_id_o    = em_q.id;
  assign ok_o           = em_q.ok;
  assign result_cost_o  = em_q.cost;
  assign total_used_o   = total_q;
  assign last_o         = em_q.last;

  // A result only follows a cycle in which a command was accepted or running.
  `BRM_ASSERT_IMP(a_result_has_cause, result_valid_o, $past(busy_o || start_i), "result without a command")
  // The table never holds more assets than it has room for.
  `BRM_ASSERT(a_count_bound, cnt_q <= CW'(MAX_ASSETS), "entry count beyond table size")
  // The activation front never passes the release back.
  `BRM_ASSERT_IMP(a_walk_order, busy_o && !is_single_q, ai_q <= ri_q, "walk pointers crossed")

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for budgeted_residency_manager. A behavioural
// predictor mirrors the asset table, the deferred updates and the iteration
// ordering, and every result transaction is compared with its prediction.
// ---------------------------------------------------------------------------
module tb;

  // One predicted or observed result transaction.
  typedef struct {
    logic [2:0]                   kind;
    logic [brm_pkg::ID_W-1:0]     id;
    logic                         ok;
    logic [brm_pkg::COST_W-1:0]   cost;
    logic [brm_pkg::BUDGET_W-1:0] total;
    logic                         last;
  } residency_result_t;

  localparam logic [63:0] COST_MAX = 64'hFF_FFFF_FFFF;
  localparam logic [brm_pkg::BUDGET_W-1:0] BUDGET_MAX = 48'hFFFF_FFFF_FFFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [2:0]            mode_i = '0;
  logic [brm_pkg::ID_W-1:0]       asset_id_i = '0;
  logic signed [brm_pkg::PRIO_W-1:0] priority_req_i = '0;
  logic [brm_pkg::COST_W-1:0]     cost_i = '0;
  logic [brm_pkg::STAMP_W-1:0]    completed_count_i = '0;
  logic                  result_valid_o;
  logic [2:0]            kind_o;
  logic [brm_pkg::ID_W-1:0]       result_id_o;
  logic                  ok_o;
  logic [brm_pkg::COST_W-1:0]     result_cost_o;
  logic [brm_pkg::BUDGET_W-1:0]   total_used_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [brm_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [brm_pkg::BUDGET_W-1:0]   cfg_data_i = '0;

  budgeted_residency_manager u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The run is bounded well beyond the slowest legal schedule: every item an
  // iteration over a full table plus the longest idle burst.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Shadow copy of the block's state and configuration.
  // -------------------------------------------------------------------------
  logic [brm_pkg::BUDGET_W-1:0]      total_budget_q;
  logic [brm_pkg::BUDGET_W-1:0]      iter_budget_q;
  logic [brm_pkg::PLEVEL_W-1:0]      persist_level_q;
  int unsigned                       asset_count;
  logic signed [brm_pkg::PRIO_W-1:0] asset_prio [brm_pkg::MAX_ASSETS_DEF];
  logic [brm_pkg::STAMP_W-1:0]       asset_last_use [brm_pkg::MAX_ASSETS_DEF];
  logic [brm_pkg::COST_W-1:0]        asset_resident [brm_pkg::MAX_ASSETS_DEF];
  logic [brm_pkg::COST_W-1:0]        asset_pending [brm_pkg::MAX_ASSETS_DEF];
  logic [brm_pkg::COST_W-1:0]        asset_estimate [brm_pkg::MAX_ASSETS_DEF];
  bit                                update_held [brm_pkg::MAX_ASSETS_DEF];
  logic [brm_pkg::COST_W-1:0]        held_measure [brm_pkg::MAX_ASSETS_DEF];
  bit                                use_marked [brm_pkg::MAX_ASSETS_DEF];
  logic [brm_pkg::STAMP_W-1:0]       frame_stamp;
  logic [brm_pkg::STAMP_W-1:0]       single_activations;
  logic [brm_pkg::BUDGET_W-1:0]      used_cost;

  residency_result_t expected_results[$];
  residency_result_t step_results[$];
  int                failures = 0;
  bit                idling_on = 1'b1;

  initial begin
    total_budget_q = '0;
    iter_budget_q = '0;
    persist_level_q = brm_pkg::PLEVEL_RESET;
    asset_count = 0;
    frame_stamp = '0;
    single_activations = '0;
    used_cost = '0;
    for (int i = 0; i < brm_pkg::MAX_ASSETS_DEF; i++) begin
      update_held[i] = 1'b0;
      use_marked[i] = 1'b0;
    end
  end

  function automatic void add_result(brm_pkg::brm_kind_e kind, int unsigned id, bit ok,
                                     logic [brm_pkg::COST_W-1:0] cost);
    residency_result_t r;
    r.kind = kind;
    r.id = id[brm_pkg::ID_W-1:0];
    r.ok = ok;
    r.cost = cost;
    r.total = used_cost;
    r.last = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  // Held cost updates and use marks take effect at the current stamp; those
  // naming an unregistered asset are simply dropped.
  function automatic void apply_held_updates();
    for (int unsigned i = 0; i < brm_pkg::MAX_ASSETS_DEF; i++) begin
      if (update_held[i] && i < asset_count) begin
        used_cost = used_cost + held_measure[i] - asset_resident[i] - asset_pending[i];
        asset_resident[i] = held_measure[i];
        asset_pending[i] = '0;
        asset_last_use[i] = frame_stamp;
      end
      update_held[i] = 1'b0;
      if (use_marked[i] && i < asset_count) asset_last_use[i] = frame_stamp;
      use_marked[i] = 1'b0;
    end
  endfunction

  function automatic bit ranks_ahead(int unsigned a, int unsigned b);
    if (asset_prio[a] != asset_prio[b]) return asset_prio[a] > asset_prio[b];
    if (asset_last_use[a] != asset_last_use[b])
      return asset_last_use[a] > asset_last_use[b];
    if (asset_resident[a] != asset_resident[b])
      return asset_resident[a] < asset_resident[b];
    if (asset_pending[a] != asset_pending[b])
      return asset_pending[a] > asset_pending[b];
    return a < b;
  endfunction

  function automatic void run_frame();
    int unsigned order [brm_pkg::MAX_ASSETS_DEF];
    int unsigned j, v, c, r, head, tail;
    logic [63:0] activated, estimate, freed, low_mark, budget;
    bit fits;
    int p;
    for (int unsigned i = 0; i < asset_count; i++) begin
      v = i;
      j = i;
      while (j > 0 && ranks_ahead(v, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    head = 0;
    tail = asset_count;
    activated = '0;
    fits = 1'b1;
    budget = 64'(total_budget_q);
    while (fits && 64'(used_cost) < budget && activated < 64'(iter_budget_q)
           && head != tail) begin
      c = order[head];
      if (asset_prio[c] <= 0) break;
      if (asset_resident[c] != 0 || asset_pending[c] != 0) begin
        head++;
        continue;
      end
      estimate = 64'(asset_estimate[c]);
      fits = (64'(used_cost) + estimate <= budget) ||
             (int'(asset_prio[c]) >= int'(persist_level_q));
      // Make room by releasing from the low end of the order.
      while (!fits && head + 1 != tail) begin
        tail--;
        r = order[tail];
        if (asset_resident[r] != 0) begin
          freed = 64'(asset_resident[r]);
          used_cost = used_cost - freed[brm_pkg::BUDGET_W-1:0];
          asset_resident[r] = '0;
          add_result(brm_pkg::KIND_RELEASE, r, 1'b1, freed[brm_pkg::COST_W-1:0]);
        end
        fits = 64'(used_cost) + estimate <= budget;
      end
      if (fits) begin
        asset_pending[c] = estimate[brm_pkg::COST_W-1:0];
        used_cost = used_cost + estimate[brm_pkg::BUDGET_W-1:0];
        activated = activated + estimate;
        head++;
        add_result(brm_pkg::KIND_ACTIVATE, c, 1'b1, estimate[brm_pkg::COST_W-1:0]);
      end
    end
    // Early release: over budget, or above three quarters for priority zero.
    low_mark = (budget * 3) / 4;
    while (tail != head) begin
      p = int'(asset_prio[order[tail-1]]);
      if (p >= int'(persist_level_q)) break;
      if (!(64'(used_cost) > budget || (64'(used_cost) > low_mark && p == 0))) break;
      tail--;
      r = order[tail];
      if (asset_resident[r] != 0) begin
        freed = 64'(asset_resident[r]);
        used_cost = used_cost - freed[brm_pkg::BUDGET_W-1:0];
        asset_resident[r] = '0;
        asset_last_use[r] = '0;
        add_result(brm_pkg::KIND_RELEASE, r, 1'b1, freed[brm_pkg::COST_W-1:0]);
      end
    end
    frame_stamp = frame_stamp + 1;
    add_result(brm_pkg::KIND_DONE, 0, 1'b1,
               activated > COST_MAX ? COST_MAX[brm_pkg::COST_W-1:0] :
                                      activated[brm_pkg::COST_W-1:0]);
  endfunction

  function automatic void predict_command(logic [2:0] mode, logic [brm_pkg::ID_W-1:0] id,
                                          logic signed [brm_pkg::PRIO_W-1:0] prio,
                                          logic [brm_pkg::COST_W-1:0] cost,
                                          logic [brm_pkg::STAMP_W-1:0] completed);
    logic [brm_pkg::STAMP_W-1:0] backlog;
    int unsigned n;
    step_results.delete();
    case (mode)
      brm_pkg::MODE_REGISTER: begin
        if (asset_count >= brm_pkg::MAX_ASSETS_DEF) begin
          add_result(brm_pkg::KIND_REGISTERED, 0, 1'b0, '0);
        end else begin
          n = asset_count;
          asset_count = asset_count + 1;
          asset_prio[n] = prio;
          asset_estimate[n] = cost;
          asset_last_use[n] = '0;
          asset_resident[n] = '0;
          asset_pending[n] = '0;
          add_result(brm_pkg::KIND_REGISTERED, n, 1'b1, '0);
        end
      end
      brm_pkg::MODE_UPDATE: begin
        update_held[id] = 1'b1;
        held_measure[id] = cost;
        add_result(brm_pkg::KIND_STATUS, id, 1'b1, '0);
      end
      brm_pkg::MODE_MARK_USED: begin
        use_marked[id] = 1'b1;
        add_result(brm_pkg::KIND_STATUS, id, 1'b1, '0);
      end
      brm_pkg::MODE_SET_PRIO: begin
        if (id < asset_count) asset_prio[id] = prio;
        add_result(brm_pkg::KIND_STATUS, id, id < asset_count, '0);
      end
      brm_pkg::MODE_ITERATE: begin
        frame_stamp = frame_stamp + single_activations;
        single_activations = '0;
        backlog = frame_stamp - completed;
        if (backlog > brm_pkg::SKIP_MARGIN && backlog < 32'h8000_0000) begin
          add_result(brm_pkg::KIND_SKIPPED, 0, 1'b1, '0);
        end else begin
          apply_held_updates();
          run_frame();
        end
      end
      brm_pkg::MODE_SINGLE: begin
        apply_held_updates();
        if (id >= asset_count) begin
          add_result(brm_pkg::KIND_STATUS, id, 1'b0, '0);
        end else if (asset_resident[id] != 0 || asset_pending[id] != 0) begin
          add_result(brm_pkg::KIND_STATUS, id, 1'b1, '0);
        end else begin
          asset_pending[id] = asset_estimate[id];
          asset_last_use[id] = frame_stamp;
          used_cost = used_cost + brm_pkg::BUDGET_W'(asset_estimate[id]);
          single_activations = single_activations + 1;
          add_result(brm_pkg::KIND_ACTIVATE, id, 1'b1, asset_estimate[id]);
        end
      end
      default: add_result(brm_pkg::KIND_STATUS, id, 1'b0, '0);
    endcase
    step_results[$].last = 1'b1;
    foreach (step_results[k]) expected_results.insert(expected_results.size(), step_results[k]);
  endfunction

  // -------------------------------------------------------------------------
  // Result checking. Results are strobes, so each one is taken at the edge
  // that closes its cycle and set against the oldest prediction.
  // -------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    residency_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(kind_o));
        check_field("result_id", 64'(want.id), 64'(result_id_o));
        check_field("ok", 64'(want.ok), 64'(ok_o));
        check_field("result_cost", 64'(want.cost), 64'(result_cost_o));
        check_field("total_used", 64'(want.total), 64'(total_used_o));
        check_field("last", 64'(want.last), 64'(last_o));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus. Every task is entered and left on a rising edge.
  // -------------------------------------------------------------------------
  task automatic send_command(logic [2:0] mode, logic [brm_pkg::ID_W-1:0] id,
                              logic signed [brm_pkg::PRIO_W-1:0] prio,
                              logic [brm_pkg::COST_W-1:0] cost,
                              logic [brm_pkg::STAMP_W-1:0] completed);
    start_i <= 1'b1;
    mode_i <= mode;
    asset_id_i <= id;
    priority_req_i <= prio;
    cost_i <= cost;
    completed_count_i <= completed;
    do @(posedge clk_i); while (busy_o);
    predict_command(mode, id, prio, cost, completed);
    // Start is left high for back-to-back commands unless a gap is drawn.
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Stop issuing commands and wait until every expected result has arrived.
  task automatic drain();
    start_i <= 1'b0;
    while (expected_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(brm_pkg::brm_cfg_e index,
                                logic [brm_pkg::BUDGET_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      brm_pkg::CFG_TOTAL_BUDGET: total_budget_q = value;
      brm_pkg::CFG_ITER_BUDGET:  iter_budget_q = value;
      default:                   persist_level_q = value[brm_pkg::PLEVEL_W-1:0];
    endcase
  endtask

  task automatic configure(logic [brm_pkg::BUDGET_W-1:0] total,
                           logic [brm_pkg::BUDGET_W-1:0] per_frame,
                           logic [brm_pkg::PLEVEL_W-1:0] level);
    drain();
    write_register(brm_pkg::CFG_TOTAL_BUDGET, total);
    write_register(brm_pkg::CFG_ITER_BUDGET, per_frame);
    write_register(brm_pkg::CFG_PERSIST_LEVEL, brm_pkg::BUDGET_W'(level));
    @(posedge clk_i);
  endtask

  function automatic logic [brm_pkg::STAMP_W-1:0] next_stamp();
    return frame_stamp + single_activations;
  endfunction

  function automatic logic [brm_pkg::COST_W-1:0] random_cost();
    case ($urandom_range(0, 7))
      0:       return brm_pkg::COST_W'({$urandom, $urandom});
      1:       return '0;
      default: return brm_pkg::COST_W'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic logic signed [brm_pkg::PRIO_W-1:0] random_prio();
    case ($urandom_range(0, 7))
      0:       return -8'sd128;
      1:       return 8'sd127;
      2:       return brm_pkg::PRIO_W'($urandom);
      default: return brm_pkg::PRIO_W'($urandom_range(0, 14) - 4);
    endcase
  endfunction

  // Pending work mostly within the margin, sometimes ahead or far behind.
  function automatic logic [brm_pkg::STAMP_W-1:0] random_completed();
    case ($urandom_range(0, 9))
      0:       return next_stamp() - 4 - $urandom_range(0, 20);
      1:       return next_stamp() + $urandom_range(1, 5);
      2:       return $urandom;
      default: return next_stamp() - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [brm_pkg::ID_W-1:0] random_id();
    if ($urandom_range(0, 4) == 0) return brm_pkg::ID_W'($urandom);
    return brm_pkg::ID_W'($urandom_range(0, asset_count + 1));
  endfunction

  task automatic send_random_command();
    int unsigned pick;
    logic [2:0] mode;
    pick = $urandom_range(0, 99);
    if (pick < 12)      mode = brm_pkg::MODE_REGISTER;
    else if (pick < 32) mode = brm_pkg::MODE_UPDATE;
    else if (pick < 47) mode = brm_pkg::MODE_MARK_USED;
    else if (pick < 59) mode = brm_pkg::MODE_SET_PRIO;
    else if (pick < 80) mode = brm_pkg::MODE_ITERATE;
    else if (pick < 97) mode = brm_pkg::MODE_SINGLE;
    else                mode = 3'($urandom_range(6, 7));
    send_command(mode, random_id(), random_prio(), random_cost(), random_completed());
  endtask

  // Every operation, the field extremes, the skip window edges and the
  // single-activation corner cases.
  task automatic test_directed();
    configure(48'd3000, 48'd2000, 7'd6);
    send_command(brm_pkg::MODE_REGISTER, 5'd0, 8'sd127, COST_MAX[brm_pkg::COST_W-1:0], '0);
    send_command(brm_pkg::MODE_REGISTER, 5'd31, -8'sd128, '0, '1);
    send_command(brm_pkg::MODE_REGISTER, 5'd0, 8'sd0, 40'd700, '0);
    send_command(brm_pkg::MODE_REGISTER, 5'd0, 8'sd5, 40'd100, '0);
    send_command(brm_pkg::MODE_REGISTER, 5'd0, 8'sd3, 40'd900, '0);
    send_command(brm_pkg::MODE_UPDATE, 5'd2, 8'sd0, 40'd1200, '0);
    send_command(brm_pkg::MODE_UPDATE, 5'd2, 8'sd0, 40'd800, '0);
    send_command(brm_pkg::MODE_UPDATE, 5'd31, 8'sd0, '1, '0);
    send_command(brm_pkg::MODE_MARK_USED, 5'd4, 8'sd0, '0, '0);
    send_command(brm_pkg::MODE_MARK_USED, 5'd31, 8'sd0, '0, '0);
    send_command(brm_pkg::MODE_SET_PRIO, 5'd31, 8'sd9, '0, '0);
    send_command(brm_pkg::MODE_SET_PRIO, 5'd1, 8'sd2, '0, '0);
    send_command(brm_pkg::MODE_ITERATE, 5'd0, 8'sd0, '0, next_stamp());
    send_command(brm_pkg::MODE_ITERATE, 5'd0, 8'sd0, '0, next_stamp() - 4);
    send_command(brm_pkg::MODE_ITERATE, 5'd0, 8'sd0, '0, next_stamp() - 3);
    send_command(brm_pkg::MODE_ITERATE, 5'd0, 8'sd0, '0, next_stamp() + 1);
    send_command(brm_pkg::MODE_SINGLE, 5'd2, 8'sd0, '0, '0);
    send_command(brm_pkg::MODE_SINGLE, 5'd1, 8'sd0, '0, '0);
    send_command(brm_pkg::MODE_SINGLE, 5'd1, 8'sd0, '0, '0);
    send_command(brm_pkg::MODE_SINGLE, 5'd20, 8'sd0, '0, '0);
    send_command(3'd6, 5'd3, 8'sd0, '0, '0);
    send_command(3'd7, 5'd31, -8'sd1, '1, '1);
    send_command(brm_pkg::MODE_ITERATE, 5'd0, 8'sd0, '0, next_stamp());
  endtask

  task automatic test_random_phase(int unsigned count, logic [brm_pkg::BUDGET_W-1:0] total,
                                   logic [brm_pkg::BUDGET_W-1:0] per_frame,
                                   logic [brm_pkg::PLEVEL_W-1:0] level);
    configure(total, per_frame, level);
    repeat (count) send_random_command();
  endtask

  // Fill the table to the top and register once more on the full table.
  task automatic test_table_full();
    while (asset_count < brm_pkg::MAX_ASSETS_DEF)
      send_command(brm_pkg::MODE_REGISTER, random_id(), random_prio(), random_cost(), '0);
    send_command(brm_pkg::MODE_REGISTER, 5'd0, 8'sd1, 40'd1, '0);
    send_command(brm_pkg::MODE_ITERATE, 5'd0, 8'sd0, '0, next_stamp());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(70, 48'd5000, 48'd3000, 7'd8);
    test_random_phase(70, BUDGET_MAX, BUDGET_MAX, 7'd127);
    test_random_phase(70, 48'd0, 48'd0, 7'd0);
    test_table_full();
    test_random_phase(70, 48'd2000, BUDGET_MAX, 7'd5);
    test_random_phase(70, 48'd1500, 48'd800, 7'd127);
    // The final stretch runs without idle gaps.
    idling_on = 1'b0;
    test_random_phase(70, brm_pkg::BUDGET_W'({$urandom, $urandom}),
                      brm_pkg::BUDGET_W'({$urandom, $urandom}), 7'($urandom));
    drain();
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
